FILE: rtl/core/ptd_pkg.sv
// Shared constants and types for the trial-division primality tester.
`default_nettype none

package ptd_pkg;

  // Width of the candidate field on the input port.
  localparam int unsigned CandidateW = 32;

  // Default arithmetic width of the candidate and the divisor search.
  localparam int unsigned PtdWidth = 32;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_DIV   = 4'b0100,
    S_FIN   = 4'b1000
  } ptd_state_e;

endpackage

`default_nettype wire

FILE: rtl/core/primality_trial_division.sv
// Top level of the trial-division primality tester.
`default_nettype none

// Takes one candidate per transaction and returns one is_prime bit. Zero and one
// go straight to the finish state and come back as not prime from the output
// register without a search. Otherwise the divisors 2, 3, ... are tried through
// one shared bit-serial divider, each trial passing through the start and divide
// states. The search ends at the first divisor that divides evenly or once the
// quotient falls below the divisor, so an item runs one trial per divisor from 2
// up to d, d being the divisor tried last: about the square root of the candidate
// for a prime. The input is not ready while a search runs; a finished result
// waits in the output register and a new candidate may be taken meanwhile. A
// search that ends while that register is still full holds its result, and the
// input stays closed, until the register is taken.
module primality_trial_division
  import ptd_pkg::*;
#(
  parameter int unsigned WIDTH = PtdWidth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  candidate_valid_i,
  output logic                       candidate_ready_o,
  input  wire logic [CandidateW-1:0] candidate_i,
  output logic                       is_prime_valid_o,
  input  wire logic                  is_prime_ready_i,
  output logic                       is_prime_o
);

  ptd_state_e       state_q, state_d;
  logic [WIDTH-1:0] cand_q, cand_d;
  logic [WIDTH-1:0] divisor_q, divisor_d;
  logic             prime_q, prime_d;
  logic             out_valid_q, out_valid_d;
  logic             out_bit_q, out_bit_d;

  logic [WIDTH-1:0] cand_ext;
  logic             in_hs;
  logic             div_start;
  logic             div_done;
  logic [WIDTH-1:0] quotient;
  logic [WIDTH-1:0] remainder;
  logic             out_free;

  assign cand_ext          = WIDTH'(candidate_i);
  assign candidate_ready_o = (state_q == S_IDLE);
  assign in_hs             = candidate_valid_i && candidate_ready_o;
  assign div_start         = (state_q == S_START);
  assign out_free          = !out_valid_q || is_prime_ready_i;

  ptd_divider #(
    .WIDTH(WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cand_q),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .quotient_o (quotient),
    .remainder_o(remainder)
  );

  always_comb begin
    state_d     = state_q;
    cand_d      = cand_q;
    divisor_d   = divisor_q;
    prime_d     = prime_q;
    out_valid_d = out_valid_q;
    out_bit_d   = out_bit_q;

    if (out_valid_q && is_prime_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_hs) begin
          cand_d = cand_ext;
          if (cand_ext < WIDTH'(2)) begin
            divisor_d = '0;
            prime_d   = 1'b0;
            state_d   = S_FIN;
          end else begin
            divisor_d = WIDTH'(2);
            state_d   = S_START;
          end
        end
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          // Quotient below the divisor: no divisor up to the square root is left.
          priority if (quotient < divisor_q) begin
            divisor_d = cand_q;
            prime_d   = 1'b1;
            state_d   = S_FIN;
          end else if (remainder == '0) begin
            prime_d = 1'b0;
            state_d = S_FIN;
          end else begin
            divisor_d = divisor_q + WIDTH'(1);
            state_d   = S_START;
          end
        end
      end
      S_FIN: begin
        // Hold until the output register can take the result.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_bit_d   = prime_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cand_q      <= '0;
      divisor_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cand_q      <= cand_d;
      divisor_q   <= divisor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prime_q   <= prime_d;
    out_bit_q <= out_bit_d;
  end

  assign is_prime_valid_o = out_valid_q;
  assign is_prime_o       = out_bit_q;

endmodule

`default_nettype wire

FILE: rtl/core/ptd_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module ptd_divider #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] dividend_i,
  input  wire logic [WIDTH-1:0] divisor_i,
  output logic                  done_o,
  output logic [WIDTH-1:0]      quotient_o,
  output logic [WIDTH-1:0]      remainder_o
);

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] div_q, div_d;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;

  // Bring down the next dividend bit and try the subtraction.
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign fits    = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WIDTH);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

FILE: rtl/core/ptd_checker.sv
// Port-level assertions for the primality tester, bound to the top level.
`default_nettype none

module ptd_checker
  import ptd_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  candidate_valid_i,
  input wire logic                  candidate_ready_o,
  input wire logic [CandidateW-1:0] candidate_i,
  input wire logic                  is_prime_valid_o,
  input wire logic                  is_prime_ready_i,
  input wire logic                  is_prime_o
);

  // A waiting candidate stays offered with the same value.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    candidate_valid_i && !candidate_ready_o |=> candidate_valid_i && $stable(candidate_i))
    else $error("candidate changed or withdrawn before its transaction completed");

  // A pending result stays offered until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_prime_valid_o && !is_prime_ready_i |=> is_prime_valid_o)
    else $error("result dropped before its transaction completed");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_prime_valid_o && !is_prime_ready_i |=> $stable(is_prime_o))
    else $error("result changed while stalled");

  // Accepting a candidate makes the block busy at once.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    candidate_valid_i && candidate_ready_o |=> !candidate_ready_o)
    else $error("input still ready right after a transaction");

  // A fresh result appears exactly when the search ends and the input reopens.
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(is_prime_valid_o) |-> candidate_ready_o)
    else $error("result appeared while the search was still busy");

endmodule

bind primality_trial_division ptd_checker u_ptd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .candidate_valid_i(candidate_valid_i),
  .candidate_ready_o(candidate_ready_o),
  .candidate_i      (candidate_i),
  .is_prime_valid_o (is_prime_valid_o),
  .is_prime_ready_i (is_prime_ready_i),
  .is_prime_o       (is_prime_o)
);

`default_nettype wire

FILE: test/primality_trial_division_test.sv
// Self-checking testbench for the trial-division primality tester.
`timescale 1ns / 1ps

module primality_trial_division_test;
  import ptd_pkg::*;

  // Keep each search short: random candidates of 2**20 and up need a factor no larger than this.
  localparam int unsigned CheapBound    = 1024;
  localparam int unsigned IdleLimit     = 200000;
  localparam int unsigned HoldOffCycles = 1500;
  localparam int unsigned DrainCycles   = 50;
  localparam int unsigned MaxReports    = 10;

  typedef logic [CandidateW-1:0] cand_t;

  typedef struct packed {
    cand_t candidate;
    logic  is_prime;
  } verdict_t;

  logic  clk_i           = 1'b0;
  logic  rst_ni          = 1'b0;
  logic  candidate_valid = 1'b0;
  cand_t candidate       = '0;
  logic  is_prime_ready  = 1'b0;
  logic  candidate_ready;
  logic  is_prime_valid;
  logic  is_prime;

  verdict_t    pending_verdicts[$];
  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned primes_seen     = 0;
  int unsigned items_sent      = 0;
  int unsigned hold_off_req    = 0;
  bit          tx_no_idle      = 1'b0;
  bit          rx_no_idle      = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  primality_trial_division u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .candidate_valid_i (candidate_valid),
    .candidate_ready_o (candidate_ready),
    .candidate_i       (candidate),
    .is_prime_valid_o  (is_prime_valid),
    .is_prime_ready_i  (is_prime_ready),
    .is_prime_o        (is_prime)
  );

  // Smallest divisor of n (n >= 2), or n itself when none lies at or below its root.
  function automatic cand_t smallest_factor(input cand_t n);
    logic [63:0] d;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return cand_t'(d);
    end
    return n;
  endfunction

  // Zero and one are not prime; otherwise prime when the search runs out.
  function automatic logic primality_of(input cand_t n);
    if (n < 2) begin
      return 1'b0;
    end
    return smallest_factor(n) == n;
  endfunction

  function automatic bit cheap_search(input cand_t n);
    return n < (1 << 20) || smallest_factor(n) <= CheapBound;
  endfunction

  function automatic cand_t random_candidate();
    cand_t       n;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) n = $urandom_range(0, 3);
    else if (pick <= 3) n = $urandom_range(0, 4095);
    else if (pick <= 5) n = $urandom_range(0, (1 << 20) - 1);
    else begin
      do n = $urandom; while (!cheap_search(n));
    end
    return n;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one candidate and hold it until the transaction completes.
  task automatic send_candidate(input cand_t value);
    int unsigned gap;
    verdict_t    want;
    gap = tx_no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      candidate_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    candidate_valid <= 1'b1;
    candidate       <= value;
    do @(posedge clk_i); while (!candidate_ready);
    want.candidate = value;
    want.is_prime  = primality_of(value);
    if (want.is_prime) primes_seen++;
    pending_verdicts.push_back(want);
    items_sent++;
  endtask

  // Drop valid after the last transaction so nothing is taken twice.
  task automatic close_offer();
    candidate_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_all_verdicts();
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input cand_t cand, input logic want,
                                 input logic got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("mismatch (%0s): candidate %0d expected is_prime %b, got %b",
               what, cand, want, got);
    end
  endtask

  task automatic test_directed_extremes();
    cand_t corners[] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
      32'd63001,       // 251 squared
      32'd65521,       // largest 16-bit prime
      32'd65535,
      32'd1048573,     // prime just below 2**20
      32'd1052651,     // 1021 * 1031
      32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'hAAAA_AAAA,
      32'h5555_5555, 32'hFFFF_0000
    };
    foreach (corners[i]) send_candidate(corners[i]);
  endtask

  task automatic test_random_mix();
    repeat (60) send_candidate(random_candidate());
  endtask

  // Stall the result side long enough that the block backs up into its input.
  task automatic test_back_pressure();
    tx_no_idle = 1'b1;
    hold_off_req <= hold_off_req + 1;
    repeat (8) send_candidate($urandom_range(0, 63));
    tx_no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (6) send_candidate(random_candidate());
    close_offer();
    wait_all_verdicts();
    repeat (6) send_candidate(random_candidate());
  endtask

  task automatic test_back_to_back();
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    repeat (12) send_candidate(random_candidate());
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    verdict_t head;
    if (rst_ni && is_prime_valid && is_prime_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("no transaction pending", '0, 1'bx, is_prime);
      end else begin
        head = pending_verdicts.pop_front();
        results_checked++;
        if (is_prime !== head.is_prime) begin
          report_mismatch("is_prime", head.candidate, head.is_prime, is_prime);
        end
      end
    end
  end

  // Result side: random ready, plus one long hold-off on request.
  initial begin
    int unsigned stall_left;
    int unsigned gap;
    int unsigned seen;
    stall_left = 0;
    gap        = 0;
    seen       = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req != seen) begin
        seen       = hold_off_req;
        stall_left = HoldOffCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        is_prime_ready <= 1'b0;
      end else if (rx_no_idle) begin
        is_prime_ready <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        is_prime_ready <= 1'b0;
      end else begin
        is_prime_ready <= 1'b1;
        gap = pick_gap();
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((candidate_valid && candidate_ready) || (is_prime_valid && is_prime_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no transaction for %0d cycles", IdleLimit);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_random_mix();
    test_back_pressure();
    test_drain_pause();
    test_back_to_back();
    close_offer();
    wait_all_verdicts();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d candidates (%0d prime, edge values and full 32-bit range) under",
             items_sent, primes_seen);
    $display("random idling, a %0d-cycle result stall and a full drain; %0d checked, %0d bad",
             HoldOffCycles, results_checked, mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
